@@ rtl/acd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package acd_pkg;

    // Blink period in ticks, and the width of the blink counter.
    localparam int unsigned ACD_BLINK_PERIOD_DEF = 250;
    localparam int unsigned ACD_BLINK_W          = 8;

    // Time limits.
    localparam logic [6:0] ACD_MINUTES_PER_HOUR = 7'd60;
    localparam logic [5:0] ACD_HOURS_PER_DAY    = 6'd24;
    localparam logic [4:0] ACD_NOON             = 5'd12;

    // Alarm time after reset.
    localparam logic [4:0] ACD_ALARM_HOURS_RST   = 5'd11;
    localparam logic [5:0] ACD_ALARM_MINUTES_RST = 6'd59;

    // Symbol codes for the decoder beyond the decimal digits.
    localparam logic [3:0] ACD_SYM_COLON = 4'd10;
    localparam logic [3:0] ACD_SYM_PM    = 4'd11;
    localparam logic [3:0] ACD_SYM_BLANK = 4'd12;

    typedef struct packed {
        logic       button_hour;
        logic       button_minute;
        logic       button_mode;
        logic       button_format;
        logic       button_view;
        logic [4:0] clock_hours;
        logic [5:0] clock_minutes;
        logic       audio_playing;
    } t_tick;

    typedef struct packed {
        logic [4:0] digit_enable;
        logic [6:0] segments_n;
        logic       clock_write;
        logic [4:0] new_clock_hours;
        logic [5:0] new_clock_minutes;
        logic [4:0] alarm_hours_out;
        logic [5:0] alarm_minutes_out;
        logic       stop_audio;
    } t_disp;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
    } t_time;

    // What the scan needs from the control logic for one tick.
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic       pm;
        logic       flash;
    } t_view;

    // Results of the button and time logic for one tick.
    typedef struct packed {
        logic       clock_write;
        t_time      clock;
        t_time      alarm;
        logic       stop_audio;
    } t_ctl_res;

    // Adds an hour and/or a minute; minutes of 60 or more carry, hours wrap at 24.
    function automatic t_time time_add(input t_time t, input logic dh, input logic dm);
        logic [5:0] h;
        logic [6:0] m;
        t_time      r;
        h = {1'b0, t.hours} + {5'd0, dh};
        m = {1'b0, t.minutes} + {6'd0, dm};
        if (m >= ACD_MINUTES_PER_HOUR) begin
            m = 7'd0;
            h = h + 6'd1;
        end
        if (h >= ACD_HOURS_PER_DAY) begin
            h = 6'd0;
        end
        r.hours   = h[4:0];
        r.minutes = m[5:0];
        return r;
    endfunction

    // Tens digit of a value below 64: multiply by 13/128.
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [10:0] p;
        p = {5'd0, v} * 11'd13;
        return p[10:7];
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [6:0] p;
        p = {1'b0, v} - ({3'd0, tens_of(v)} * 7'd10);
        return p[3:0];
    endfunction

    // Lit segments, bit0 = A through bit6 = G; anything else is dark.
    function automatic logic [6:0] seg_on(input logic [3:0] v);
        logic [6:0] s;
        unique case (v)
            4'd0:          s = 7'h3F;
            4'd1:          s = 7'h06;
            4'd2:          s = 7'h5B;
            4'd3:          s = 7'h4F;
            4'd4:          s = 7'h66;
            4'd5:          s = 7'h6D;
            4'd6:          s = 7'h7D;
            4'd7:          s = 7'h07;
            4'd8:          s = 7'h7F;
            4'd9:          s = 7'h6F;
            ACD_SYM_COLON: s = 7'h03;
            ACD_SYM_PM:    s = 7'h04;
            default:       s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/acd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one transfer per display tick.
interface acd_tick_if;
    logic       valid;
    logic       ready;
    logic       button_hour;
    logic       button_minute;
    logic       button_mode;
    logic       button_format;
    logic       button_view;
    logic [4:0] clock_hours;
    logic [5:0] clock_minutes;
    logic       audio_playing;

    modport source (
        output valid, button_hour, button_minute, button_mode, button_format,
               button_view, clock_hours, clock_minutes, audio_playing,
        input  ready
    );
    modport sink (
        input  valid, button_hour, button_minute, button_mode, button_format,
               button_view, clock_hours, clock_minutes, audio_playing,
        output ready
    );
endinterface

// Result channel: one transfer per tick.
interface acd_disp_if;
    logic       valid;
    logic       ready;
    logic [4:0] digit_enable;
    logic [6:0] segments_n;
    logic       clock_write;
    logic [4:0] new_clock_hours;
    logic [5:0] new_clock_minutes;
    logic [4:0] alarm_hours_out;
    logic [5:0] alarm_minutes_out;
    logic       stop_audio;

    modport source (
        output valid, digit_enable, segments_n, clock_write, new_clock_hours,
               new_clock_minutes, alarm_hours_out, alarm_minutes_out, stop_audio,
        input  ready
    );
    modport sink (
        input  valid, digit_enable, segments_n, clock_write, new_clock_hours,
               new_clock_minutes, alarm_hours_out, alarm_minutes_out, stop_audio,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/acd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire acd_pkg::t_tick    i_tick,
    output acd_pkg::t_view         o_view,
    output acd_pkg::t_ctl_res      o_res
);
    import acd_pkg::*;

    logic       r_set_mode, n_set_mode;
    logic       r_alarm_view, n_alarm_view;
    logic       r_twelve_hour, n_twelve_hour;
    logic       r_flash_on, n_flash_on;
    logic [4:0] r_button_held;
    t_time      r_alarm, n_alarm;

    logic [4:0] levels;
    logic [4:0] press;
    t_time      clk_t;
    t_time      shown;
    logic       cw;
    logic       stop;
    logic       pm;

    assign levels = {i_tick.button_view, i_tick.button_format, i_tick.button_mode,
                     i_tick.button_minute, i_tick.button_hour};
    assign press  = levels & ~r_button_held;

    always_comb begin
        clk_t.hours   = i_tick.clock_hours;
        clk_t.minutes = i_tick.clock_minutes;
        n_alarm       = r_alarm;
        cw            = 1'b0;
        stop          = 1'b0;

        // Hour button: snooze while audio plays, then hour increment in set mode.
        if (press[0]) begin
            if (i_tick.audio_playing) begin
                stop    = 1'b1;
                n_alarm = time_add(n_alarm, 1'b0, 1'b1);
            end
            if (r_set_mode) begin
                if (!r_alarm_view) begin
                    clk_t = time_add(clk_t, 1'b1, 1'b0);
                    cw    = 1'b1;
                end else begin
                    n_alarm = time_add(n_alarm, 1'b1, 1'b0);
                end
            end
        end

        // Minute button: stop audio, then minute increment in set mode.
        if (press[1]) begin
            if (i_tick.audio_playing) begin
                stop = 1'b1;
            end
            if (r_set_mode) begin
                if (!r_alarm_view) begin
                    clk_t = time_add(clk_t, 1'b0, 1'b1);
                    cw    = 1'b1;
                end else begin
                    n_alarm = time_add(n_alarm, 1'b0, 1'b1);
                end
            end
        end

        n_set_mode    = r_set_mode ^ press[2];
        n_flash_on    = r_flash_on ^ press[2];
        n_twelve_hour = r_twelve_hour ^ press[3];
        n_alarm_view  = r_alarm_view ^ press[4];

        shown = n_alarm_view ? n_alarm : clk_t;
        pm    = n_twelve_hour && (shown.hours >= ACD_NOON);
        if (pm) begin
            shown.hours = shown.hours - ACD_NOON;
        end
    end

    assign o_view.hours   = shown.hours;
    assign o_view.minutes = shown.minutes;
    assign o_view.pm      = pm;
    assign o_view.flash   = n_flash_on;

    assign o_res.clock_write   = cw;
    assign o_res.clock.hours   = cw ? clk_t.hours : 5'd0;
    assign o_res.clock.minutes = cw ? clk_t.minutes : 6'd0;
    assign o_res.alarm         = n_alarm;
    assign o_res.stop_audio    = stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_mode      <= 1'b0;
            r_alarm_view    <= 1'b0;
            r_twelve_hour   <= 1'b0;
            r_flash_on      <= 1'b0;
            r_button_held   <= 5'd0;
            r_alarm.hours   <= ACD_ALARM_HOURS_RST;
            r_alarm.minutes <= ACD_ALARM_MINUTES_RST;
        end else if (i_fire) begin
            r_set_mode    <= n_set_mode;
            r_alarm_view  <= n_alarm_view;
            r_twelve_hour <= n_twelve_hour;
            r_flash_on    <= n_flash_on;
            r_button_held <= levels;
            r_alarm       <= n_alarm;
        end
    end

endmodule

`default_nettype wire

@@ rtl/acd_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acd_scan #(
    parameter int unsigned BLINK_PERIOD = acd_pkg::ACD_BLINK_PERIOD_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire acd_pkg::t_view i_view,
    output logic [4:0]         o_digit_enable,
    output logic [6:0]         o_segments_n
);
    import acd_pkg::*;

    localparam logic [ACD_BLINK_W-1:0] BlinkHalf = ACD_BLINK_W'(BLINK_PERIOD / 2);
    localparam logic [ACD_BLINK_W:0]   BlinkEnd  = (ACD_BLINK_W + 1)'(BLINK_PERIOD);

    // Scan positions.
    localparam logic [2:0] POS_HOUR_TENS = 3'd1;
    localparam logic [2:0] POS_HOUR_ONES = 3'd2;
    localparam logic [2:0] POS_MIN_TENS  = 3'd3;
    localparam logic [2:0] POS_MIN_ONES  = 3'd4;
    localparam logic [2:0] POS_COLON     = 3'd5;
    localparam logic [2:0] POS_PM        = 3'd6;

    logic                   r_scan_phase;
    logic [2:0]             r_scan_position, n_scan_position;
    logic [ACD_BLINK_W-1:0] r_blink_count, n_blink_count;
    logic [4:0]             r_digit_lines, n_digit_lines;
    logic [6:0]             r_segment_lines, n_segment_lines;

    logic [3:0]             value;
    logic [4:0]             enable;
    logic                   blink;
    logic                   lit;
    logic [ACD_BLINK_W:0]   count_inc;
    logic [3:0]             advance;
    logic [3:0]             last;

    always_comb begin
        value           = ACD_SYM_BLANK;
        enable          = 5'd0;
        blink           = 1'b0;
        lit             = 1'b1;
        n_blink_count   = r_blink_count;
        n_digit_lines   = r_digit_lines;
        n_segment_lines = r_segment_lines;
        n_scan_position = r_scan_position;
        count_inc       = {1'b0, r_blink_count} + 1'b1;
        advance         = {1'b0, r_scan_position} + 4'd1;
        last            = i_view.pm ? {1'b0, POS_PM} : {1'b0, POS_COLON};

        unique case (r_scan_position)
            POS_HOUR_TENS: begin
                value  = tens_of({1'b0, i_view.hours});
                enable = 5'b00001;
                blink  = i_view.flash;
            end
            POS_HOUR_ONES: begin
                value  = ones_of({1'b0, i_view.hours});
                enable = 5'b00010;
                blink  = i_view.flash;
            end
            POS_MIN_TENS: begin
                value  = tens_of(i_view.minutes);
                enable = 5'b00100;
                blink  = i_view.flash;
            end
            POS_MIN_ONES: begin
                value  = ones_of(i_view.minutes);
                enable = 5'b01000;
                blink  = i_view.flash;
            end
            POS_COLON: begin
                value  = ACD_SYM_COLON;
                enable = 5'b10000;
                blink  = i_view.flash;
            end
            POS_PM: begin
                value  = ACD_SYM_PM;
                enable = 5'b10000;
            end
            default: begin
                value  = ACD_SYM_BLANK;
                enable = 5'd0;
            end
        endcase

        if (!r_scan_phase) begin
            // First tick of a position: rewrite the lines.
            if (blink) begin
                lit           = r_blink_count < BlinkHalf;
                n_blink_count = (count_inc >= BlinkEnd) ? '0 : count_inc[ACD_BLINK_W-1:0];
            end
            n_digit_lines   = lit ? enable : 5'd0;
            n_segment_lines = ~seg_on(value);
        end else begin
            // Second tick: lines hold, position moves on.
            n_scan_position = (advance > last) ? POS_HOUR_TENS : advance[2:0];
        end
    end

    assign o_digit_enable = n_digit_lines;
    assign o_segments_n   = n_segment_lines;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_phase    <= 1'b0;
            r_scan_position <= POS_HOUR_TENS;
            r_blink_count   <= '0;
            r_digit_lines   <= 5'd0;
            r_segment_lines <= 7'h7F;
        end else if (i_fire) begin
            r_scan_phase    <= ~r_scan_phase;
            r_scan_position <= n_scan_position;
            r_blink_count   <= n_blink_count;
            r_digit_lines   <= n_digit_lines;
            r_segment_lines <= n_segment_lines;
        end
    end

endmodule

`default_nettype wire

@@ rtl/alarm_clock_display_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Alarm clock display controller. Each transfer on i_tick is one 500 Hz tick
// carrying the five button levels, the running clock time and the audio flag;
// each tick produces exactly one transfer on o_disp with the digit select, the
// active-low segment lines, an optional clock write-back, the alarm setting and
// a stop-audio request. Buttons act on their press edge only. The block takes
// a new tick in every cycle while o_disp.ready is high: a tick is captured in
// an input register, worked through the button, time and scan logic in a
// cycle in which the result register is empty or being emptied, and its
// result is written to the output register at the end of that cycle. The
// sustained rate is one tick per cycle while the output is not stalled, set
// by the two register stages. When the output is stalled the input register
// still takes one further tick before i_tick.ready falls; i_tick.ready
// follows o_disp.ready combinationally. BLINK_PERIOD (2 to 256) sets the
// flash period in scanned digit ticks; digits are lit for its first half.
module alarm_clock_display_controller #(
    parameter int unsigned BLINK_PERIOD = acd_pkg::ACD_BLINK_PERIOD_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    acd_tick_if.sink   i_tick,
    acd_disp_if.source o_disp
);
    import acd_pkg::*;

    // Input register stage.
    logic     r_in_valid;
    t_tick    r_in;
    t_tick    in_payload;

    // Result register stage.
    logic     r_out_valid;
    t_disp    r_out;
    t_disp    n_out;

    logic     out_free;
    logic     fire;
    t_view    view;
    t_ctl_res ctl_res;
    logic [4:0] digit_enable;
    logic [6:0] segments_n;

    // The work stage may run when it holds a tick and the result register is
    // empty or being emptied in this cycle.
    assign out_free     = !r_out_valid || o_disp.ready;
    assign fire         = r_in_valid && out_free;
    assign i_tick.ready = !r_in_valid || out_free;

    assign in_payload.button_hour   = i_tick.button_hour;
    assign in_payload.button_minute = i_tick.button_minute;
    assign in_payload.button_mode   = i_tick.button_mode;
    assign in_payload.button_format = i_tick.button_format;
    assign in_payload.button_view   = i_tick.button_view;
    assign in_payload.clock_hours   = i_tick.clock_hours;
    assign in_payload.clock_minutes = i_tick.clock_minutes;
    assign in_payload.audio_playing = i_tick.audio_playing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.valid && i_tick.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in <= in_payload;
        end
    end

    // Button edges, set/format/view toggles and the time arithmetic.
    acd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_tick  (r_in),
        .o_view  (view),
        .o_res   (ctl_res)
    );

    // Digit scan, blink counter and segment decode.
    acd_scan #(
        .BLINK_PERIOD (BLINK_PERIOD)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_view         (view),
        .o_digit_enable (digit_enable),
        .o_segments_n   (segments_n)
    );

    assign n_out.digit_enable      = digit_enable;
    assign n_out.segments_n        = segments_n;
    assign n_out.clock_write       = ctl_res.clock_write;
    assign n_out.new_clock_hours   = ctl_res.clock.hours;
    assign n_out.new_clock_minutes = ctl_res.clock.minutes;
    assign n_out.alarm_hours_out   = ctl_res.alarm.hours;
    assign n_out.alarm_minutes_out = ctl_res.alarm.minutes;
    assign n_out.stop_audio        = ctl_res.stop_audio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_disp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_disp.valid             = r_out_valid;
    assign o_disp.digit_enable      = r_out.digit_enable;
    assign o_disp.segments_n        = r_out.segments_n;
    assign o_disp.clock_write       = r_out.clock_write;
    assign o_disp.new_clock_hours   = r_out.new_clock_hours;
    assign o_disp.new_clock_minutes = r_out.new_clock_minutes;
    assign o_disp.alarm_hours_out   = r_out.alarm_hours_out;
    assign o_disp.alarm_minutes_out = r_out.alarm_minutes_out;
    assign o_disp.stop_audio        = r_out.stop_audio;

endmodule

`default_nettype wire

@@ tb/alarm_clock_display_controller_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the alarm clock display controller. A queue of ticks
// is filled up front: a short directed opening, then long runs of button level
// sequences over a drifting clock time. A clocked driver offers them on i_tick
// and a clocked monitor checks every o_disp transfer against a model of the
// block kept here. The model covers the press edges, the time increments, the
// snooze, the three toggles, the display scan, blinking and segment decoding.
module alarm_clock_display_controller_tb;

    import acd_pkg::*;

    localparam int unsigned BLINK      = ACD_BLINK_PERIOD_DEF;
    localparam int unsigned N_RANDOM   = 1725;
    // Once fewer ticks than this remain queued, neither side idles any more.
    localparam int unsigned TAIL_TICKS = 200;
    // The receiver's long hold-off starts after this many result transfers.
    localparam int unsigned HOLD_AFTER = 600;
    localparam int unsigned HOLD_LEN   = 64;

    logic i_clk;
    logic i_rst_n;

    acd_tick_if tick_if ();
    acd_disp_if disp_if ();

    alarm_clock_display_controller #(
        .BLINK_PERIOD(BLINK)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tick (tick_if.sink),
        .o_disp (disp_if.source)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Ticks still to be offered, and displays still to arrive, oldest first.
    t_tick tick_queue[$];
    t_disp due_frames[$];

    t_tick       on_wire;
    t_disp       want_frame;
    int unsigned ticks_total = 0;
    int unsigned ticks_sent  = 0;
    int unsigned mismatches  = 0;

    // Model state, starting from the values the block takes at reset.
    bit          m_set       = 1'b0;
    bit          m_alarmview = 1'b0;
    bit          m_twelve    = 1'b0;
    bit          m_flash     = 1'b0;
    logic [4:0]  m_held      = 5'd0;
    bit          m_phase     = 1'b0;
    int unsigned m_pos       = 1;
    int unsigned m_blink     = 0;
    int unsigned m_alarm_h   = ACD_ALARM_HOURS_RST;
    int unsigned m_alarm_m   = ACD_ALARM_MINUTES_RST;
    logic [4:0]  m_digits    = 5'd0;
    logic [6:0]  m_segs      = 7'h7F;

    // Minutes reaching 60 or more clear and carry an hour; hours of 24 or more
    // clear. Out-of-range inputs are treated by the same two comparisons.
    function automatic void bump_time(inout int unsigned h, inout int unsigned m,
                                      input int unsigned dh, input int unsigned dm);
        h = h + dh;
        m = m + dm;
        if (m >= 60) begin
            m = 0;
            h = h + 1;
        end
        if (h >= 24) begin
            h = 0;
        end
    endfunction

    // Lit segments of a digit or symbol, bit 0 = A; unknown codes stay dark.
    function automatic logic [6:0] glyph(input int unsigned code);
        case (code)
            0:             return 7'h3F;
            1:             return 7'h06;
            2:             return 7'h5B;
            3:             return 7'h4F;
            4:             return 7'h66;
            5:             return 7'h6D;
            6:             return 7'h7D;
            7:             return 7'h07;
            8:             return 7'h7F;
            9:             return 7'h6F;
            ACD_SYM_COLON: return 7'h03;
            ACD_SYM_PM:    return 7'h04;
            default:       return 7'h00;
        endcase
    endfunction

    // Rewrites the digit and segment lines for one scan position. A blinking
    // position advances the blink count and is dark in the second half of it.
    function automatic void light(input int unsigned pos, input int unsigned code,
                                  input bit blink);
        bit lit;
        lit      = 1'b1;
        m_digits = 5'd0;
        if (pos >= 1 && pos <= 5) begin
            if (blink) begin
                lit     = m_blink < BLINK / 2;
                m_blink = (m_blink + 1 >= BLINK) ? 0 : m_blink + 1;
            end
            if (lit) begin
                m_digits = 5'd1 << (pos - 1);
            end
        end
        m_segs = ~glyph(code);
    endfunction

    // Works one accepted tick through the model and queues the display it gives.
    task automatic advance_display(input t_tick t);
        logic [4:0]  lv;
        logic [4:0]  press;
        int unsigned ch;
        int unsigned cm;
        int unsigned hrs;
        int unsigned mins;
        int unsigned last;
        bit          cw;
        bit          stop;
        t_disp       d;
        lv     = {t.button_view, t.button_format, t.button_mode,
                  t.button_minute, t.button_hour};
        press  = lv & ~m_held;
        m_held = lv;
        ch     = t.clock_hours;
        cm     = t.clock_minutes;
        cw     = 1'b0;
        stop   = 1'b0;

        // Hour button: snooze first, then the set-mode hour increment.
        if (press[0]) begin
            if (t.audio_playing) begin
                stop = 1'b1;
                bump_time(m_alarm_h, m_alarm_m, 0, 1);
            end
            if (m_set) begin
                if (!m_alarmview) begin
                    bump_time(ch, cm, 1, 0);
                    cw = 1'b1;
                end else begin
                    bump_time(m_alarm_h, m_alarm_m, 1, 0);
                end
            end
        end
        // Minute button: stop only, then the set-mode minute increment, which
        // builds on any hour increment of the same tick.
        if (press[1]) begin
            if (t.audio_playing) begin
                stop = 1'b1;
            end
            if (m_set) begin
                if (!m_alarmview) begin
                    bump_time(ch, cm, 0, 1);
                    cw = 1'b1;
                end else begin
                    bump_time(m_alarm_h, m_alarm_m, 0, 1);
                end
            end
        end
        // The toggles come after the increments, so those used the old modes.
        if (press[2]) begin
            m_flash = !m_flash;
            m_set   = !m_set;
        end
        if (press[3]) begin
            m_twelve = !m_twelve;
        end
        if (press[4]) begin
            m_alarmview = !m_alarmview;
        end

        hrs  = m_alarmview ? m_alarm_h : ch;
        mins = m_alarmview ? m_alarm_m : cm;
        last = 5;
        if (m_twelve && hrs >= ACD_NOON) begin
            hrs  = hrs - ACD_NOON;
            last = 6;
        end

        // The first tick of a position rewrites the lines; the second holds
        // them and moves on. A PM position left over from a format change is
        // still shown once before the scan wraps.
        if (!m_phase) begin
            case (m_pos)
                1:       light(1, hrs / 10, m_flash);
                2:       light(2, hrs % 10, m_flash);
                3:       light(3, mins / 10, m_flash);
                4:       light(4, mins % 10, m_flash);
                5:       light(5, ACD_SYM_COLON, m_flash);
                6:       light(5, ACD_SYM_PM, 1'b0);
                default: light(0, ACD_SYM_BLANK, 1'b0);
            endcase
            m_phase = 1'b1;
        end else begin
            m_phase = 1'b0;
            m_pos   = (m_pos + 1 > last) ? 1 : m_pos + 1;
        end

        d.digit_enable      = m_digits;
        d.segments_n        = m_segs;
        d.clock_write       = cw;
        d.new_clock_hours   = cw ? ch[4:0] : 5'd0;
        d.new_clock_minutes = cw ? cm[5:0] : 6'd0;
        d.alarm_hours_out   = m_alarm_h[4:0];
        d.alarm_minutes_out = m_alarm_m[5:0];
        d.stop_audio        = stop;
        due_frames.push_back(d);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic queue_tick(input bit bh, input bit bm, input bit bmode,
                              input bit bfmt, input bit bview, input int unsigned h,
                              input int unsigned m, input bit audio);
        t_tick t;
        t.button_hour   = bh;
        t.button_minute = bm;
        t.button_mode   = bmode;
        t.button_format = bfmt;
        t.button_view   = bview;
        t.clock_hours   = h[4:0];
        t.clock_minutes = m[5:0];
        t.audio_playing = audio;
        tick_queue.push_back(t);
        ticks_total++;
    endtask

    // Driver. A transfer at this edge is handed to the model first; then the
    // next tick goes up unless an idle burst is running. Idle bursts follow a
    // transfer at random, but not in the tail of the run.
    int unsigned send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                advance_display(on_wire);
                ticks_sent++;
                if (tick_queue.size() > TAIL_TICKS && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 4);
                end
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    tick_if.valid <= 1'b0;
                end else if (tick_queue.size() > 0) begin
                    on_wire = tick_queue.pop_front();
                    tick_if.valid         <= 1'b1;
                    tick_if.button_hour   <= on_wire.button_hour;
                    tick_if.button_minute <= on_wire.button_minute;
                    tick_if.button_mode   <= on_wire.button_mode;
                    tick_if.button_format <= on_wire.button_format;
                    tick_if.button_view   <= on_wire.button_view;
                    tick_if.clock_hours   <= on_wire.clock_hours;
                    tick_if.clock_minutes <= on_wire.clock_minutes;
                    tick_if.audio_playing <= on_wire.audio_playing;
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Random stall bursts, and once a long hold-off while the driver
    // keeps offering, so that both register stages fill and i_tick.ready has to
    // fall.
    int unsigned rx_seen  = 0;
    int unsigned rx_stall = 0;
    int unsigned rx_hold  = 0;
    bit          held_off = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            disp_if.ready <= 1'b0;
        end else begin
            if (disp_if.valid && disp_if.ready) begin
                rx_seen++;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                disp_if.ready <= 1'b0;
            end else if (!held_off && rx_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                rx_hold  = HOLD_LEN - 1;
                disp_if.ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                disp_if.ready <= 1'b0;
            end else if (tick_queue.size() > TAIL_TICKS && $urandom_range(0, 9) == 0) begin
                rx_stall = $urandom_range(1, 4) - 1;
                disp_if.ready <= 1'b0;
            end else begin
                disp_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: every result transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && disp_if.valid && disp_if.ready) begin
            if (due_frames.size() == 0) begin
                $error("display transfer with no tick outstanding");
                mismatches++;
            end else begin
                want_frame = due_frames.pop_front();
                check_field("digit_enable", want_frame.digit_enable, disp_if.digit_enable);
                check_field("segments_n", want_frame.segments_n, disp_if.segments_n);
                check_field("clock_write", want_frame.clock_write, disp_if.clock_write);
                check_field("new_clock_hours", want_frame.new_clock_hours,
                            disp_if.new_clock_hours);
                check_field("new_clock_minutes", want_frame.new_clock_minutes,
                            disp_if.new_clock_minutes);
                check_field("alarm_hours_out", want_frame.alarm_hours_out,
                            disp_if.alarm_hours_out);
                check_field("alarm_minutes_out", want_frame.alarm_minutes_out,
                            disp_if.alarm_minutes_out);
                check_field("stop_audio", want_frame.stop_audio, disp_if.stop_audio);
            end
        end
    end

    initial begin : stimulus
        bit          lv_h;
        bit          lv_m;
        bit          lv_mode;
        bit          lv_fmt;
        bit          lv_view;
        bit          aud;
        int unsigned hh;
        int unsigned mm;
        int unsigned r;

        i_rst_n               = 1'b0;
        tick_if.valid         = 1'b0;
        tick_if.button_hour   = 1'b0;
        tick_if.button_minute = 1'b0;
        tick_if.button_mode   = 1'b0;
        tick_if.button_format = 1'b0;
        tick_if.button_view   = 1'b0;
        tick_if.clock_hours   = 5'd0;
        tick_if.clock_minutes = 6'd0;
        tick_if.audio_playing = 1'b0;
        disp_if.ready         = 1'b0;

        // Directed opening. Button arguments: hour, minute, mode, format, view.
        queue_tick(0, 0, 0, 0, 0, 0, 0, 0);
        queue_tick(1, 0, 0, 0, 0, 23, 59, 1);   // snooze carries the alarm to 12:00
        queue_tick(0, 1, 0, 0, 0, 23, 59, 1);   // minute press only stops the audio
        queue_tick(0, 0, 0, 0, 0, 23, 59, 0);
        queue_tick(0, 0, 1, 0, 0, 23, 59, 0);   // into set mode, flashing starts
        queue_tick(0, 0, 0, 0, 0, 23, 59, 0);
        queue_tick(1, 0, 0, 0, 0, 23, 59, 0);   // hour wraps past 23
        queue_tick(0, 0, 0, 0, 0, 23, 59, 0);
        queue_tick(0, 1, 0, 0, 0, 23, 59, 0);   // minute carry and hour wrap together
        queue_tick(0, 0, 0, 0, 0, 23, 59, 0);
        queue_tick(1, 1, 0, 0, 0, 23, 59, 0);   // both increments build on one another
        queue_tick(0, 0, 0, 0, 1, 23, 59, 0);   // alarm view
        queue_tick(0, 0, 0, 0, 0, 23, 59, 0);
        queue_tick(1, 0, 0, 0, 0, 23, 59, 0);   // alarm hour increment
        queue_tick(0, 1, 0, 0, 0, 23, 59, 1);   // alarm minute increment with a stop
        queue_tick(0, 0, 0, 1, 0, 13, 45, 0);   // 12 hour format
        queue_tick(0, 0, 0, 0, 0, 13, 45, 0);
        queue_tick(0, 0, 0, 0, 1, 13, 45, 0);   // back to the clock, now past noon
        queue_tick(0, 0, 0, 0, 0, 13, 45, 0);
        queue_tick(1, 1, 1, 1, 1, 31, 63, 1);   // every press at once, clock out of range
        queue_tick(0, 0, 0, 0, 0, 31, 63, 0);
        queue_tick(0, 0, 0, 1, 0, 31, 63, 0);   // back to 12 hour, maybe with PM pending
        queue_tick(0, 0, 0, 0, 0, 31, 63, 0);
        queue_tick(0, 0, 1, 0, 0, 12, 0, 0);
        queue_tick(0, 0, 0, 0, 0, 12, 0, 0);

        // Random part: button levels that persist over several ticks, so most
        // changes are clean press and release pairs. Set mode changes slowly
        // enough for the blink count to run through both halves of its period.
        lv_h    = 1'b0;
        lv_m    = 1'b0;
        lv_mode = 1'b0;
        lv_fmt  = 1'b0;
        lv_view = 1'b0;
        aud     = 1'b0;
        hh      = 12;
        mm      = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 3) == 0) lv_h = !lv_h;
            if ($urandom_range(0, 3) == 0) lv_m = !lv_m;
            if ($urandom_range(0, 149) == 0) lv_mode = !lv_mode;
            if ($urandom_range(0, 39) == 0) lv_fmt = !lv_fmt;
            if ($urandom_range(0, 29) == 0) lv_view = !lv_view;
            if ($urandom_range(0, 24) == 0) aud = !aud;
            r = $urandom_range(0, 15);
            if (r == 0) begin
                // Anything the fields can carry, out of range included.
                hh = $urandom_range(0, 31);
                mm = $urandom_range(0, 63);
            end else if (r <= 3) begin
                hh = $urandom_range(0, 23);
                mm = $urandom_range(0, 59);
            end else if (r == 4) begin
                bump_time(hh, mm, 0, 1);
            end
            queue_tick(lv_h, lv_m, lv_mode, lv_fmt, lv_view, hh, mm, aud);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ticks_sent < ticks_total) @(posedge i_clk);
        while (due_frames.size() != 0) @(posedge i_clk);
        // Two register stages; a few more cycles catch any stray transfer.
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // The slowest correct run ends well inside this timeout.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
